/* rtl/core/pfcc_pkg.sv */
// ----------------------------------------------------------------------------
// pfcc_pkg
// Shared types and constants for the parent forest cycle checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcc_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ENTRY_W   = IDX_W + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_CYCLE    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_UNSEEN = 2'd0,
    MARK_PATH   = 2'd1,
    MARK_DONE   = 2'd2,
    MARK_UNUSED = 2'd3
  } mark_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;       // store the accepted node
    logic    walk_init;  // start, cursor to node 0
    logic    clr_wr;     // clear mark at start, step start
    logic    mark_wr;    // write mark at cursor
    mark_e   mark_val;
    logic    advance;    // cursor follows parent link
    logic    restart;    // cursor back to start
    logic    next_start; // start and cursor to start + 1
    logic    emit;       // load the result register
    status_e res_status;
  } pfcc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  ld_ovf;
    logic  ld_range;
    logic  start_last;
    logic  cur_dead;
    mark_e mark;
    logic  out_free;
  } pfcc_sts_t;

endpackage

`default_nettype wire

/* rtl/core/pfcc_ctrl.sv */
// ----------------------------------------------------------------------------
// pfcc_ctrl
// Sequencer for loading, visit map clearing and the two-pass chain walk.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  input  wire                 s_axis_tlast_i,
  output logic                s_axis_tready_o,
  input  pfcc_pkg::pfcc_sts_t sts_i,
  output pfcc_pkg::pfcc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLEAR,
    S_W1_RD,
    S_W1_EV,
    S_W2_RD,
    S_W2_EV,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  pfcc_pkg::status_e   res_q, res_d;
  logic                accept;

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.mark_val   = pfcc_pkg::MARK_UNSEEN;
    cmd_o.res_status = res_q;
    case (state_q)
      S_LOAD: begin
        cmd_o.load = accept;
        if (accept && s_axis_tlast_i) begin
          if (sts_i.ld_ovf) begin
            res_d   = pfcc_pkg::ST_OVERFLOW;
            state_d = S_DONE;
          end else if (sts_i.ld_range) begin
            res_d   = pfcc_pkg::ST_RANGE;
            state_d = S_DONE;
          end else begin
            cmd_o.walk_init = 1'b1;
            state_d         = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.start_last) begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_W1_RD;
        end
      end
      S_W1_RD: begin
        if (sts_i.cur_dead) begin
          cmd_o.restart = 1'b1;
          state_d       = S_W2_RD;
        end else begin
          state_d = S_W1_EV;
        end
      end
      S_W1_EV: begin
        case (sts_i.mark)
          pfcc_pkg::MARK_UNSEEN: begin
            cmd_o.mark_wr  = 1'b1;
            cmd_o.mark_val = pfcc_pkg::MARK_PATH;
            cmd_o.advance  = 1'b1;
            state_d        = S_W1_RD;
          end
          pfcc_pkg::MARK_PATH: begin
            res_d   = pfcc_pkg::ST_CYCLE;
            state_d = S_DONE;
          end
          default: begin
            cmd_o.restart = 1'b1;
            state_d       = S_W2_RD;
          end
        endcase
      end
      S_W2_RD, S_W2_EV: begin
        if (state_q == S_W2_RD && !sts_i.cur_dead) begin
          state_d = S_W2_EV;
        end else if (state_q == S_W2_EV && sts_i.mark == pfcc_pkg::MARK_PATH) begin
          cmd_o.mark_wr  = 1'b1;
          cmd_o.mark_val = pfcc_pkg::MARK_DONE;
          cmd_o.advance  = 1'b1;
          state_d        = S_W2_RD;
        end else if (sts_i.start_last) begin
          res_d   = pfcc_pkg::ST_OK;
          state_d = S_DONE;
        end else begin
          cmd_o.next_start = 1'b1;
          state_d          = S_W1_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      res_q   <= pfcc_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pfcc_dp.sv */
// ----------------------------------------------------------------------------
// pfcc_dp
// Parent table, visit map, load counters, walk cursor and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcc_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [pfcc_pkg::IDX_W-1:0]         parent_index_i,
  input  wire                                is_root_i,
  input  pfcc_pkg::pfcc_cmd_t                cmd_i,
  output pfcc_pkg::pfcc_sts_t                sts_o,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  output logic [15:0]                        m_axis_tdata_o
);

  localparam int IW = pfcc_pkg::IDX_W;
  localparam int CW = pfcc_pkg::CNT_W;
  localparam logic [CW-1:0] MaxCnt = CW'(pfcc_pkg::MAX_NODES);

  logic [pfcc_pkg::ENTRY_W-1:0] parent_mem [pfcc_pkg::MAX_NODES];
  logic [1:0]                   mark_mem   [pfcc_pkg::MAX_NODES];

  logic [CW-1:0]  count_q;
  logic [IW-1:0]  max_q;
  logic           ovf_q;
  logic [IW-1:0]  start_q;
  logic [IW-1:0]  cur_q;
  logic           cur_dead_q;
  logic [pfcc_pkg::ENTRY_W-1:0] link_q;
  logic [1:0]     mark_rd_q;

  logic           m_valid_q;
  logic [1:0]     out_status_q;
  logic [CW-1:0]  out_count_q;

  logic           room;
  logic [CW-1:0]  count_nx;
  logic [IW-1:0]  max_nx;
  logic           ovf_nx;
  logic           start_last;
  logic [IW-1:0]  mark_wa;
  logic [1:0]     mark_wd;
  logic           mark_we;
  logic [IW-1:0]  start_inc;

  // next values of the load counters for the node being accepted
  always_comb begin
    room     = (count_q < MaxCnt);
    count_nx = count_q + CW'(room);
    max_nx   = max_q;
    if (room && !is_root_i && parent_index_i > max_q) begin
      max_nx = parent_index_i;
    end
    ovf_nx = ovf_q | ~room;
  end

  assign start_inc  = start_q + IW'(1);
  assign start_last = ((CW'(start_q) + CW'(1)) == count_q);

  assign mark_we = cmd_i.clr_wr | cmd_i.mark_wr;
  assign mark_wa = cmd_i.clr_wr ? start_q : cur_q;
  assign mark_wd = cmd_i.clr_wr ? pfcc_pkg::MARK_UNSEEN : cmd_i.mark_val;

  always_comb begin
    sts_o.ld_ovf     = ovf_nx;
    sts_o.ld_range   = ({1'b0, max_nx} >= count_nx);
    sts_o.start_last = start_last;
    sts_o.cur_dead   = cur_dead_q;
    sts_o.mark       = pfcc_pkg::mark_e'(mark_rd_q);
    sts_o.out_free   = ~m_valid_q | m_axis_tready_i;
  end

  // memories: one write port, registered read at the cursor
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      parent_mem[count_q[IW-1:0]] <= {is_root_i, parent_index_i};
    end
    link_q <= parent_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd_q <= mark_mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      max_q      <= '0;
      ovf_q      <= 1'b0;
      start_q    <= '0;
      cur_q      <= '0;
      cur_dead_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        count_q <= '0;
        max_q   <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        count_q <= count_nx;
        max_q   <= max_nx;
        ovf_q   <= ovf_nx;
      end

      if (cmd_i.walk_init) begin
        start_q    <= '0;
        cur_q      <= '0;
        cur_dead_q <= 1'b0;
      end else if (cmd_i.clr_wr) begin
        start_q <= start_inc;
      end else if (cmd_i.advance) begin
        cur_q      <= link_q[IW-1:0];
        cur_dead_q <= link_q[IW];
      end else if (cmd_i.restart) begin
        cur_q      <= start_q;
        cur_dead_q <= 1'b0;
      end else if (cmd_i.next_start) begin
        start_q    <= start_inc;
        cur_q      <= start_inc;
        cur_dead_q <= 1'b0;
      end

      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.res_status;
      out_count_q  <= count_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, out_status_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("node count above table depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.res_status == pfcc_pkg::ST_OVERFLOW) |-> (count_q == MaxCnt))
    else $error("overflow reported with table not full");

  a_mark_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_wr |-> !cur_dead_q)
    else $error("mark written past a root");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> m_valid_q)
    else $error("result lost");

endmodule

`default_nettype wire

/* rtl/core/parent_forest_cycle_check.sv */
// ----------------------------------------------------------------------------
// parent_forest_cycle_check
// Stores a set of parent links and reports whether they form a valid forest.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                    tuser    tlast
//  s_axis    in   [9:0] parent_index                       is_root  last_node
//  m_axis    out  [1:0] status, [12:2] node_count          -        -
//
//  Loading accepts one node per cycle while the input is ready; a set is one
//  item per node. After the last node the check runs: a pass that clears the
//  visit map, then the walk, which reads and evaluates each visit-map entry in
//  separate states (one port each on the parent table and visit map).
//  Range and overflow results skip the walk and go to the done state.
//  Input is held off during the check; the result register lets loading of
//  the next set run while a result waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module parent_forest_cycle_check (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [9:0] parent_index
  input  wire         s_axis_tuser_i,   // [0] is_root
  input  wire         s_axis_tlast_i,   // last_node
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] status, [12:2] node_count
);

  pfcc_pkg::pfcc_cmd_t cmd;
  pfcc_pkg::pfcc_sts_t sts;

  pfcc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  pfcc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .parent_index_i  (s_axis_tdata_i[pfcc_pkg::IDX_W-1:0]),
    .is_root_i       (s_axis_tuser_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
